FILE: rtl/core/pcxrle_pkg.sv
// ----------------------------------------------------------------------------
// PCX RLE line decoder package
// Shared widths, codes, reset values and the command/status bundles that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int BYTE_W     = 8;
  localparam int COUNT_BITS = 6;
  localparam int DIM_W      = 17;
  localparam int CFG_IDX_W  = 2;

  // Run header marker: both top bits set
  localparam logic [BYTE_W-1:0] FLAG_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] CNT_MASK  = ~FLAG_MASK;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = 2'd1;

  localparam logic [DIM_W-1:0] LINE_WIDTH_RESET = 17'd320;
  localparam logic [DIM_W-1:0] LINE_COUNT_RESET = 17'd240;

  // Controller to datapath
  typedef struct packed {
    logic emit;      // load the output register and advance the position
    logic src_in;    // pixel and count come from the input item
    logic lit;       // input item is a literal pixel (count of one)
    logic last;      // emitted pixel is the final one of its item
    logic hdr_load;  // capture a run header
    logic val_take;  // consume the pending run header
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register can take a pixel this cycle
    logic img_done;   // every line of the image is out
    logic awaiting;   // a run header waits for its value
    logic is_hdr;     // input item is a run header
    logic pend_zero;  // pending run count is zero
    logic pend_one;   // pending run count is one
    logic cnt_one;    // one repeat left in the active run
    logic eol;        // next pixel ends its line
  } sts_t;

endpackage

FILE: rtl/core/pcxrle_in_if.sv
// ----------------------------------------------------------------------------
// PCX RLE input channel
// Valid/ready channel that carries one coded byte per item.
// ----------------------------------------------------------------------------
interface pcxrle_in_if;
  logic                           valid;
  logic                           ready;
  logic [pcxrle_pkg::BYTE_W-1:0]  coded_byte;

  modport source (output valid, output coded_byte, input ready);
  modport sink   (input valid, input coded_byte, output ready);
endinterface

FILE: rtl/core/pcxrle_out_if.sv
// ----------------------------------------------------------------------------
// PCX RLE result channel
// Valid/ready channel that carries one decoded pixel with its tags per item.
// ----------------------------------------------------------------------------
interface pcxrle_out_if;
  logic                           valid;
  logic                           ready;
  logic [pcxrle_pkg::BYTE_W-1:0]  pixel;
  logic                           end_of_line;
  logic                           end_of_image;
  logic                           last;

  modport source (output valid, output pixel, output end_of_line,
                  output end_of_image, output last, input ready);
  modport sink   (input valid, input pixel, input end_of_line,
                  input end_of_image, input last, output ready);
endinterface

FILE: rtl/core/pcx_rle_line_decoder_top.sv
// PCX RLE line decoder, 8 bits per pixel, single plane.
// in_ch takes one coded byte per item; out_ch gives one decoded pixel per
// item with end_of_line, end_of_image and last (final pixel of its byte).
// cfg_we/cfg_index/cfg_data write line_width (index 0) and line_count
// (index 1); write them only while the decoder is idle.
// The first pixel of a byte sits in the output register in the cycle
// after the byte is taken. A literal byte or a run header is taken
// whenever the output register is free. A run value byte holds the input
// while the run counter steps through its repeats, up to 63, into the
// single output register. A run stops at the end of its line and its
// surplus repeats are dropped. Once the last line is out, bytes are taken
// and dropped.
// Reset (rst_n low, synchronous) sets 320 x 240 and clears the position,
// the pending run header and the output valid flag.
// When the receiver stalls, the output register holds its pixel and the
// decoder stalls with it; in the cycle the held pixel leaves, a new byte
// is taken, or in a run the next repeat is loaded.
// ----------------------------------------------------------------------------
// PCX RLE line decoder top level
// Joins the controller and the datapath to the channels and config port.
// ----------------------------------------------------------------------------
module pcx_rle_line_decoder_top (
  input  logic                              clk,
  input  logic                              rst_n,
  pcxrle_in_if.sink                         in_ch,
  pcxrle_out_if.source                      out_ch,
  input  logic                              cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcxrle_pkg::DIM_W-1:0]      cfg_data
);

  pcxrle_pkg::cmd_t cmd;
  pcxrle_pkg::sts_t sts;

  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcxrle_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .coded_byte   (in_ch.coded_byte),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .pixel        (out_ch.pixel),
    .end_of_line  (out_ch.end_of_line),
    .end_of_image (out_ch.end_of_image),
    .last         (out_ch.last),
    .cmd          (cmd),
    .sts          (sts)
  );

`ifndef ASSERT_OFF
  // A pixel that ends the image also ends its line
  a_eoi_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_image |-> out_ch.end_of_line)
    else $error("end_of_image without end_of_line");

  // A run never crosses a line end
  a_eol_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.end_of_line |-> out_ch.last)
    else $error("end_of_line pixel not last of its item");

  // After the final pixel of the image, the image is finished
  a_img_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && sts.eol && !sts.img_done && $past(1'b1) && u_dp.eoi |=> sts.img_done)
    else $error("image not finished after end_of_image");

  // Never load the output register while it holds an untaken pixel
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("output register overrun");
`endif

endmodule

FILE: rtl/core/pcxrle_ctrl.sv
// ----------------------------------------------------------------------------
// PCX RLE controller
// Decides per cycle whether to take a coded byte, capture a run header,
// or emit a pixel, and walks through the repeats of a run.
// ----------------------------------------------------------------------------
module pcxrle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcxrle_pkg::sts_t   sts,
  output pcxrle_pkg::cmd_t   cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Decode the next action
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = sts.out_free;
        if (in_valid && sts.out_free && !sts.img_done) begin
          if (sts.awaiting) begin
            cmd.val_take = 1'b1;
            if (!sts.pend_zero) begin
              cmd.emit   = 1'b1;
              cmd.src_in = 1'b1;
              cmd.last   = sts.eol || sts.pend_one;
              if (!(sts.eol || sts.pend_one)) begin
                state_nxt = ST_RUN;
              end
            end
          end else if (sts.is_hdr) begin
            cmd.hdr_load = 1'b1;
          end else begin
            cmd.emit   = 1'b1;
            cmd.src_in = 1'b1;
            cmd.lit    = 1'b1;
            cmd.last   = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = sts.eol || sts.cnt_one;
          if (sts.eol || sts.cnt_one) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/pcxrle_dp.sv
// ----------------------------------------------------------------------------
// PCX RLE datapath
// Holds the geometry registers, decode position, run header, run counter
// and the output register; reports status to the controller.
// ----------------------------------------------------------------------------
module pcxrle_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [pcxrle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pcxrle_pkg::DIM_W-1:0]          cfg_data,
  input  logic [pcxrle_pkg::BYTE_W-1:0]         coded_byte,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic [pcxrle_pkg::BYTE_W-1:0]         pixel,
  output logic                                  end_of_line,
  output logic                                  end_of_image,
  output logic                                  last,
  input  pcxrle_pkg::cmd_t                      cmd,
  output pcxrle_pkg::sts_t                      sts
);

  logic [pcxrle_pkg::DIM_W-1:0]      line_width_r, line_width_nxt;
  logic [pcxrle_pkg::DIM_W-1:0]      line_count_r, line_count_nxt;
  logic [pcxrle_pkg::DIM_W-1:0]      column_r, column_nxt;
  logic [pcxrle_pkg::DIM_W-1:0]      row_r, row_nxt;
  logic                              awaiting_r, awaiting_nxt;
  logic [pcxrle_pkg::COUNT_BITS-1:0] pending_r, pending_nxt;
  logic [pcxrle_pkg::COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [pcxrle_pkg::BYTE_W-1:0]     value_r, value_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [pcxrle_pkg::BYTE_W-1:0]     pixel_r, pixel_nxt;
  logic                              eol_r, eol_nxt;
  logic                              eoi_r, eoi_nxt;
  logic                              last_r, last_nxt;

  logic [pcxrle_pkg::DIM_W-1:0]      w_eff;
  logic [pcxrle_pkg::DIM_W-1:0]      h_eff;
  logic [pcxrle_pkg::DIM_W:0]        col_inc;
  logic [pcxrle_pkg::DIM_W:0]        row_inc;
  logic                              eol;
  logic                              eoi;
  logic [pcxrle_pkg::BYTE_W-1:0]     pix_sel;
  logic [pcxrle_pkg::COUNT_BITS-1:0] n_cur;
  logic                              out_free;

  // Treat a zero geometry register as one
  assign w_eff = (line_width_r == '0) ? pcxrle_pkg::DIM_W'(1) : line_width_r;
  assign h_eff = (line_count_r == '0) ? pcxrle_pkg::DIM_W'(1) : line_count_r;

  // Line and image boundary for the next pixel
  assign col_inc = {1'b0, column_r} + (pcxrle_pkg::DIM_W+1)'(1);
  assign row_inc = {1'b0, row_r} + (pcxrle_pkg::DIM_W+1)'(1);
  assign eol     = col_inc >= {1'b0, w_eff};
  assign eoi     = eol && (row_inc >= {1'b0, h_eff});

  // Select pixel value and repeat count for this emission
  assign pix_sel = cmd.src_in ? coded_byte : value_r;
  always_comb begin
    if (!cmd.src_in) begin
      n_cur = cnt_r;
    end else if (cmd.lit) begin
      n_cur = pcxrle_pkg::COUNT_BITS'(1);
    end else begin
      n_cur = pending_r;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Status toward the controller
  always_comb begin
    sts.out_free  = out_free;
    sts.img_done  = row_r >= h_eff;
    sts.awaiting  = awaiting_r;
    sts.is_hdr    = (coded_byte & pcxrle_pkg::FLAG_MASK) == pcxrle_pkg::FLAG_MASK;
    sts.pend_zero = pending_r == '0;
    sts.pend_one  = pending_r == pcxrle_pkg::COUNT_BITS'(1);
    sts.cnt_one   = cnt_r == pcxrle_pkg::COUNT_BITS'(1);
    sts.eol       = eol;
  end

  // Configuration writes
  always_comb begin
    line_width_nxt = line_width_r;
    line_count_nxt = line_count_r;
    if (cfg_we) begin
      case (cfg_index)
        pcxrle_pkg::REG_LINE_WIDTH: line_width_nxt = cfg_data;
        pcxrle_pkg::REG_LINE_COUNT: line_count_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Run header capture and release
  always_comb begin
    awaiting_nxt = awaiting_r;
    pending_nxt  = pending_r;
    if (cmd.hdr_load) begin
      awaiting_nxt = 1'b1;
      pending_nxt  = coded_byte[pcxrle_pkg::COUNT_BITS-1:0];
    end else if (cmd.val_take) begin
      awaiting_nxt = 1'b0;
    end
  end

  // Advance position and run counter on each pixel
  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    cnt_nxt    = cnt_r;
    value_nxt  = value_r;
    if (cmd.emit) begin
      cnt_nxt   = n_cur - pcxrle_pkg::COUNT_BITS'(1);
      value_nxt = pix_sel;
      if (eol) begin
        column_nxt = '0;
        row_nxt    = row_inc[pcxrle_pkg::DIM_W-1:0];
      end else begin
        column_nxt = col_inc[pcxrle_pkg::DIM_W-1:0];
      end
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    pixel_nxt     = pixel_r;
    eol_nxt       = eol_r;
    eoi_nxt       = eoi_r;
    last_nxt      = last_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      pixel_nxt     = pix_sel;
      eol_nxt       = eol;
      eoi_nxt       = eoi;
      last_nxt      = cmd.last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= pcxrle_pkg::LINE_WIDTH_RESET;
      line_count_r <= pcxrle_pkg::LINE_COUNT_RESET;
      column_r     <= '0;
      row_r        <= '0;
      awaiting_r   <= 1'b0;
      pending_r    <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      line_width_r <= line_width_nxt;
      line_count_r <= line_count_nxt;
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      awaiting_r   <= awaiting_nxt;
      pending_r    <= pending_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    pixel_r <= pixel_nxt;
    eol_r   <= eol_nxt;
    eoi_r   <= eoi_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign pixel        = pixel_r;
  assign end_of_line  = eol_r;
  assign end_of_image = eoi_r;
  assign last         = last_r;

endmodule
